### hdl/lpd_pkg.sv
// Package for the length-prefixed deframer: codes, register indexes and
// fixed field widths. No dependencies.
package lpd_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 32;
  localparam int unsigned HlenW   = 5;
  localparam int unsigned OffW    = 4;
  localparam int unsigned CfgIdxW = 3;

  // Framing phase of the stream.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  // Sequencer: accept items, or replay the stored header one byte at a time.
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_READ = 2'd1,
    SEQ_SEND = 2'd2
  } seq_e;

  // Kind of a result.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Input command.
  typedef enum logic {
    CMD_DATA    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_LENGTH = 3'd0,
    REG_LENGTH_OFFSET = 3'd1,
    REG_LENGTH_SIZE   = 3'd2,
    REG_BIG_ENDIAN    = 3'd3,
    REG_MAX_LENGTH    = 3'd4
  } reg_idx_e;

endpackage

### hdl/length_prefixed_deframer_unit.sv
// Top level of the length-prefixed deframer: header capture, length decode,
// header replay sequencer and payload pass-through. Depends on lpd_pkg.
//
// Splits a byte stream into frames of a fixed-length header and a payload
// whose length is a 2- or 4-byte field inside the header. Header bytes are
// written into a small header store as they arrive and give no result; the
// byte that completes the header either raises the length error (one result,
// then bytes are dropped until a restart command) or starts a replay of the
// store. Each replayed header byte is first read from the store into a register
// (SEQ_READ) and then loaded into the output register (SEQ_SEND), which waits
// while the output register is full; no input is taken during the replay.
// Every other item (header byte, payload byte, restart, dropped byte) is
// accepted when the output register is free or being emptied. The
// configuration port is always ready and must be written only while idle.
module length_prefixed_deframer_unit import lpd_pkg::*; #(
  parameter int unsigned MAX_HEADER = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tuser_i,   // [0] cmd
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [39:0]         m_axis_tdata_o,   // [7:0] out_byte, [39:8] bad_length
  output logic [1:0]          m_axis_tuser_o,   // [1:0] kind
  output logic                m_axis_tlast_o,   // last
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [LenW-1:0]     cfg_data_i
);

  // Index width of the header store and width of a count up to MAX_HEADER.
  localparam int unsigned HW   = $clog2(MAX_HEADER);
  localparam int unsigned CW   = $clog2(MAX_HEADER + 1);
  localparam int unsigned CMPW = (CW > HlenW) ? CW : HlenW;
  localparam int unsigned OW   = (CW > OffW) ? CW : OffW;

  // Configuration registers.
  logic [HlenW-1:0] header_length_q;
  logic [OffW-1:0]  length_offset_q;
  logic             length_size_q;
  logic             big_endian_q;
  logic [LenW-1:0]  max_length_q;

  // Framing state.
  phase_e           phase_q, phase_d;
  logic [CW-1:0]    header_count_q, header_count_d;
  logic [LenW-1:0]  payload_rem_q, payload_rem_d;
  logic [LenW-1:0]  length_accum_q, length_accum_d;

  // Replay sequencer state.
  seq_e             seq_q, seq_d;
  logic [HW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]    hl_q, hl_d;
  logic             zero_len_q, zero_len_d;

  // Header store.
  logic [ByteW-1:0] hdr_mem [MAX_HEADER];
  logic [ByteW-1:0] rd_data_q;
  logic             mem_we;
  logic             mem_re;
  logic [HW-1:0]    wr_idx;

  // Output register.
  logic             out_valid_q;
  logic [1:0]       out_kind_q, out_kind_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic [LenW-1:0]  out_bad_q, out_bad_d;
  logic             out_load;
  logic             out_free;

  // Input request decode.
  logic             in_acc;
  logic [ByteW-1:0] in_byte;
  logic             in_cmd;

  // Length decode datapath.
  logic [CMPW-1:0]  hl_raw;
  logic [CW-1:0]    hl_eff;
  logic [CW-1:0]    pos;
  logic [OW-1:0]    pos_ext;
  logic [OW-1:0]    off_ext;
  logic [OW-1:0]    fidx;
  logic             in_field;
  logic [1:0]       lane;
  logic [LenW-1:0]  byte_sh;
  logic [LenW-1:0]  accum_nx;
  logic             hdr_done;
  logic             too_long;
  logic [LenW-1:0]  rem_dec;
  logic             pay_last;
  logic             replay_last;

  assign in_byte = s_axis_tdata_i;
  assign in_cmd  = s_axis_tuser_i;

  // Configuration port; registers keep their values across restarts.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_length_q <= HlenW'(4);
      length_offset_q <= '0;
      length_size_q   <= 1'b0;
      big_endian_q    <= 1'b1;
      max_length_q    <= LenW'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HEADER_LENGTH: header_length_q <= cfg_data_i[HlenW-1:0];
        REG_LENGTH_OFFSET: length_offset_q <= cfg_data_i[OffW-1:0];
        REG_LENGTH_SIZE:   length_size_q   <= cfg_data_i[0];
        REG_BIG_ENDIAN:    big_endian_q    <= cfg_data_i[0];
        REG_MAX_LENGTH:    max_length_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective header length, the write position and the length byte merge.
  always_comb begin
    hl_raw = CMPW'(header_length_q);
    if (hl_raw == '0) begin
      hl_eff = CW'(1);
    end else if (hl_raw > CMPW'(MAX_HEADER)) begin
      hl_eff = CW'(MAX_HEADER);
    end else begin
      hl_eff = CW'(hl_raw);
    end

    // A header length lowered mid-header clamps the position to its end.
    if (header_count_q >= hl_eff) begin
      pos = hl_eff - CW'(1);
    end else begin
      pos = header_count_q;
    end
    wr_idx = pos[HW-1:0];

    pos_ext  = OW'(pos);
    off_ext  = OW'(length_offset_q);
    fidx     = pos_ext - off_ext;
    in_field = (pos_ext >= off_ext) &&
               (fidx < (length_size_q ? OW'(4) : OW'(2)));

    // Byte lane of the length word that this header byte fills.
    if (big_endian_q) begin
      lane = (length_size_q ? 2'd3 : 2'd1) - fidx[1:0];
    end else begin
      lane = fidx[1:0];
    end

    case (lane)
      2'd0:    byte_sh = {24'd0, in_byte};
      2'd1:    byte_sh = {16'd0, in_byte, 8'd0};
      2'd2:    byte_sh = {8'd0, in_byte, 16'd0};
      default: byte_sh = {in_byte, 24'd0};
    endcase

    accum_nx = length_accum_q | (in_field ? byte_sh : '0);
    hdr_done = (pos == hl_eff - CW'(1));
    too_long = (accum_nx > max_length_q);

    // Payload countdown.
    rem_dec  = (payload_rem_q != '0) ? (payload_rem_q - LenW'(1)) : '0;
    pay_last = (rem_dec == '0);

    replay_last = (CW'(rd_cnt_q) == hl_q - CW'(1));
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (seq_q == SEQ_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Sequencer next state, framing updates and result generation.
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    payload_rem_d  = payload_rem_q;
    length_accum_d = length_accum_q;
    seq_d          = seq_q;
    rd_cnt_d       = rd_cnt_q;
    hl_d           = hl_q;
    zero_len_d     = zero_len_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    out_load       = 1'b0;
    out_kind_d     = KIND_HEADER;
    out_byte_d     = '0;
    out_last_d     = 1'b0;
    out_bad_d      = '0;

    case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_RESTART) begin
            phase_d        = PH_HEADER;
            header_count_d = '0;
            payload_rem_d  = '0;
            length_accum_d = '0;
          end else begin
            case (phase_q)
              PH_PAYLOAD: begin
                out_load      = 1'b1;
                out_kind_d    = KIND_PAYLOAD;
                out_byte_d    = in_byte;
                out_last_d    = pay_last;
                payload_rem_d = rem_dec;
                if (pay_last) begin
                  phase_d        = PH_HEADER;
                  header_count_d = '0;
                  length_accum_d = '0;
                end
              end
              PH_HEADER: begin
                mem_we         = 1'b1;
                length_accum_d = accum_nx;
                if (!hdr_done) begin
                  header_count_d = pos + CW'(1);
                end else if (too_long) begin
                  // Length error: report it and drop bytes until a restart.
                  out_load       = 1'b1;
                  out_kind_d     = KIND_ERROR;
                  out_bad_d      = accum_nx;
                  phase_d        = PH_DISCARD;
                  header_count_d = '0;
                  payload_rem_d  = '0;
                end else begin
                  // Header complete: replay the store, then pass any payload.
                  hl_d           = hl_eff;
                  zero_len_d     = (accum_nx == '0);
                  rd_cnt_d       = '0;
                  seq_d          = SEQ_READ;
                  header_count_d = '0;
                  length_accum_d = '0;
                  payload_rem_d  = accum_nx;
                  phase_d        = (accum_nx == '0) ? PH_HEADER : PH_PAYLOAD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      SEQ_READ: begin
        mem_re = 1'b1;
        seq_d  = SEQ_SEND;
      end
      SEQ_SEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_HEADER;
          out_byte_d = rd_data_q;
          out_last_d = zero_len_q && replay_last;
          if (replay_last) begin
            seq_d = SEQ_IDLE;
          end else begin
            rd_cnt_d = rd_cnt_q + HW'(1);
            seq_d    = SEQ_READ;
          end
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  // Control and framing state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      payload_rem_q  <= '0;
      length_accum_q <= '0;
      seq_q          <= SEQ_IDLE;
      rd_cnt_q       <= '0;
      hl_q           <= CW'(1);
      zero_len_q     <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      payload_rem_q  <= payload_rem_d;
      length_accum_q <= length_accum_d;
      seq_q          <= seq_d;
      rd_cnt_q       <= rd_cnt_d;
      hl_q           <= hl_d;
      zero_len_q     <= zero_len_d;
    end
  end

  // Header store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hdr_mem[wr_idx] <= in_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= hdr_mem[rd_cnt_q];
    end
  end

  // Output register: valid flag under reset, payload loaded on demand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_bad_q  <= out_bad_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_bad_q, out_byte_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // An error result always leaves the block dropping bytes.
  a_error_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_kind_d == KIND_ERROR)) |=> (phase_q == PH_DISCARD))
    else $error("error result without entering the discard phase");

  // During a header replay no new header has been started.
  a_replay_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SEQ_IDLE) |-> (header_count_q == '0) && (length_accum_q == '0))
    else $error("header state not cleared during replay");

  // A replayed byte marked last only occurs for an empty payload.
  a_replay_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (seq_q == SEQ_SEND) && out_last_d) |-> (phase_q == PH_HEADER))
    else $error("header byte marked last while a payload follows");

  // The payload phase always has bytes left to pass.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (payload_rem_q != '0))
    else $error("payload phase with nothing remaining");
`endif

endmodule
